@@ sv/perspective_point_projection_defines.svh @@
// assertion macros shared by the perspective point projection rtl
`ifndef PERSPECTIVE_POINT_PROJECTION_DEFINES_SVH
`define PERSPECTIVE_POINT_PROJECTION_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off while arst_n is low
`define PPP_ASSERT_HOLDS(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ppp check failed");
// next-cycle implication, sampled on clk, off while arst_n is low
`define PPP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ppp check failed");
`else
`define PPP_ASSERT_HOLDS(label, ante, cons)
`define PPP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ sv/ppp_pkg.sv @@
// shared types and constants of the perspective point projection block
`timescale 1ns / 1ps
`default_nettype none

package ppp_pkg;

	// field and register widths
	localparam int COEF_W    = 32;
	localparam int DATA_W    = 32;
	localparam int REG_W     = 64;
	localparam int NUM_REGS  = 6;
	localparam int CFG_IDX_W = 3;
	localparam int STATUS_W  = 2;

	// matrix shape
	localparam int NUM_ROWS      = 3;
	localparam int COEFS_PER_ROW = 4;
	localparam int ROW_U = 0;
	localparam int ROW_V = 1;
	localparam int ROW_D = 2;
	localparam int COEF_X   = 0;
	localparam int COEF_Y   = 1;
	localparam int COEF_Z   = 2;
	localparam int COEF_ONE = 3;

	// register indexes
	localparam int REG_ROW1_AB = 0;
	localparam int REG_ROW1_CD = 1;
	localparam int REG_ROW2_AB = 2;
	localparam int REG_ROW2_CD = 3;
	localparam int REG_ROW3_AB = 4;
	localparam int REG_ROW3_CD = 5;

	// datapath widths
	localparam int PROD_W = 64;
	localparam int PAIR_W = 65;
	localparam int SUM_W  = 66;
	localparam int MAG_W  = 64;
	localparam int QUOT_W = 32;

	// saturation limits of a quotient
	localparam logic [QUOT_W-1:0] QUOT_POS_MAX = 32'h7FFF_FFFF;
	localparam logic [QUOT_W-1:0] QUOT_NEG_MAX = 32'h8000_0000;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_ZERO_DEN = 2'd1,
		STATUS_SAT      = 2'd2
	} status_t;

	typedef logic [COEF_W-1:0] coef_t;
	typedef coef_t [COEFS_PER_ROW-1:0] row_coef_t;
	typedef row_coef_t [NUM_ROWS-1:0] matrix_t;

	// work carried from cell to cell along the divider chain
	typedef struct packed {
		logic [MAG_W-1:0]  den;
		logic [MAG_W-1:0]  rem_u;
		logic [MAG_W-1:0]  rem_v;
		logic [QUOT_W-1:0] num_lo_u;
		logic [QUOT_W-1:0] num_lo_v;
		logic [QUOT_W-1:0] quo_u;
		logic [QUOT_W-1:0] quo_v;
		logic              neg_u;
		logic              neg_v;
		logic              big_u;
		logic              big_v;
		logic              zero_den;
	} div_work_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] image_u;
		logic signed [DATA_W-1:0] image_v;
		status_t                  status;
	} result_t;

endpackage

`default_nettype wire

@@ sv/ppp_if.sv @@
// valid/ready channel interfaces for points in and projected results out
`timescale 1ns / 1ps
`default_nettype none

interface ppp_point_if;
	logic                              valid;
	logic                              ready;
	logic signed [ppp_pkg::DATA_W-1:0] point_x;
	logic signed [ppp_pkg::DATA_W-1:0] point_y;
	logic signed [ppp_pkg::DATA_W-1:0] point_z;

	modport source (output valid, output point_x, output point_y, output point_z, input ready);
	modport sink (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface ppp_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [ppp_pkg::DATA_W-1:0]   image_u;
	logic signed [ppp_pkg::DATA_W-1:0]   image_v;
	logic        [ppp_pkg::STATUS_W-1:0] status;

	modport source (output valid, output image_u, output image_v, output status, input ready);
	modport sink (input valid, input image_u, input image_v, input status, output ready);
endinterface

`default_nettype wire

@@ sv/ppp_front.sv @@
// front end: row dot products, magnitudes and divider setup
`timescale 1ns / 1ps
`default_nettype none

module ppp_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	ppp_point_if.sink           point,
	input  ppp_pkg::matrix_t    matrix,
	output logic                div_valid,
	output ppp_pkg::div_work_t  div_work
);

	logic signed [ppp_pkg::PROD_W-1:0] prod_c  [ppp_pkg::NUM_ROWS][ppp_pkg::COEFS_PER_ROW];
	logic signed [ppp_pkg::PROD_W-1:0] prod_s1 [ppp_pkg::NUM_ROWS][ppp_pkg::COEFS_PER_ROW];
	logic signed [ppp_pkg::PAIR_W-1:0] pair_s2 [ppp_pkg::NUM_ROWS][2];
	logic signed [ppp_pkg::SUM_W-1:0]  sum_s3  [ppp_pkg::NUM_ROWS];
	logic signed [ppp_pkg::SUM_W-1:0]  sum_neg [ppp_pkg::NUM_ROWS];
	logic        [ppp_pkg::MAG_W-1:0]  mag_c   [ppp_pkg::NUM_ROWS];
	logic        [ppp_pkg::MAG_W-1:0]  mag_s4  [ppp_pkg::NUM_ROWS];
	logic                              neg_s4  [ppp_pkg::NUM_ROWS];
	logic        [ppp_pkg::MAG_W-1:0]  hi_u, hi_v, lo_u_full, lo_v_full;
	ppp_pkg::div_work_t                entry_c;
	ppp_pkg::div_work_t                work_s5;
	logic                              valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	// the whole pipeline moves together
	assign point.ready = en;

	// products of each coefficient with x, y, z; the constant term is a shift
	always_comb begin
		for (int r = 0; r < ppp_pkg::NUM_ROWS; r++) begin
			prod_c[r][ppp_pkg::COEF_X] = ppp_pkg::PROD_W'($signed(matrix[r][ppp_pkg::COEF_X]))
			                           * ppp_pkg::PROD_W'(point.point_x);
			prod_c[r][ppp_pkg::COEF_Y] = ppp_pkg::PROD_W'($signed(matrix[r][ppp_pkg::COEF_Y]))
			                           * ppp_pkg::PROD_W'(point.point_y);
			prod_c[r][ppp_pkg::COEF_Z] = ppp_pkg::PROD_W'($signed(matrix[r][ppp_pkg::COEF_Z]))
			                           * ppp_pkg::PROD_W'(point.point_z);
			prod_c[r][ppp_pkg::COEF_ONE] =
				ppp_pkg::PROD_W'($signed(matrix[r][ppp_pkg::COEF_ONE])) <<< FRAC_BITS;
		end
	end

	// magnitude and sign of each row sum
	always_comb begin
		for (int r = 0; r < ppp_pkg::NUM_ROWS; r++) begin
			sum_neg[r] = -sum_s3[r];
			mag_c[r]   = sum_s3[r][ppp_pkg::SUM_W-1] ? sum_neg[r][ppp_pkg::MAG_W-1:0]
			                                        : sum_s3[r][ppp_pkg::MAG_W-1:0];
		end
	end

	// divider setup: upper dividend part, overflow check, low dividend bits, quotient signs and zero-denominator flag
	always_comb begin
		hi_u      = mag_s4[ppp_pkg::ROW_U] >> (ppp_pkg::QUOT_W - FRAC_BITS);
		hi_v      = mag_s4[ppp_pkg::ROW_V] >> (ppp_pkg::QUOT_W - FRAC_BITS);
		lo_u_full = mag_s4[ppp_pkg::ROW_U] << FRAC_BITS;
		lo_v_full = mag_s4[ppp_pkg::ROW_V] << FRAC_BITS;

		entry_c.den      = mag_s4[ppp_pkg::ROW_D];
		entry_c.rem_u    = hi_u;
		entry_c.rem_v    = hi_v;
		entry_c.num_lo_u = lo_u_full[ppp_pkg::QUOT_W-1:0];
		entry_c.num_lo_v = lo_v_full[ppp_pkg::QUOT_W-1:0];
		entry_c.quo_u    = '0;
		entry_c.quo_v    = '0;
		entry_c.neg_u    = neg_s4[ppp_pkg::ROW_U] ^ neg_s4[ppp_pkg::ROW_D];
		entry_c.neg_v    = neg_s4[ppp_pkg::ROW_V] ^ neg_s4[ppp_pkg::ROW_D];
		entry_c.big_u    = hi_u >= mag_s4[ppp_pkg::ROW_D];
		entry_c.big_v    = hi_v >= mag_s4[ppp_pkg::ROW_D];
		entry_c.zero_den = mag_s4[ppp_pkg::ROW_D] == '0;
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= point.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < ppp_pkg::NUM_ROWS; r++) begin
				for (int c = 0; c < ppp_pkg::COEFS_PER_ROW; c++) begin
					prod_s1[r][c] <= prod_c[r][c];
				end
				pair_s2[r][0] <= ppp_pkg::PAIR_W'(prod_s1[r][ppp_pkg::COEF_X])
				               + ppp_pkg::PAIR_W'(prod_s1[r][ppp_pkg::COEF_Y]);
				pair_s2[r][1] <= ppp_pkg::PAIR_W'(prod_s1[r][ppp_pkg::COEF_Z])
				               + ppp_pkg::PAIR_W'(prod_s1[r][ppp_pkg::COEF_ONE]);
				sum_s3[r]     <= ppp_pkg::SUM_W'(pair_s2[r][0]) + ppp_pkg::SUM_W'(pair_s2[r][1]);
				mag_s4[r]     <= mag_c[r];
				neg_s4[r]     <= sum_s3[r][ppp_pkg::SUM_W-1];
			end
			work_s5 <= entry_c;
		end
	end

	assign div_valid = valid_s5;
	assign div_work  = work_s5;

endmodule

`default_nettype wire

@@ sv/ppp_div_cell.sv @@
// one cell of the divider chain: one quotient bit for both u and v
`timescale 1ns / 1ps
`default_nettype none

module ppp_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  ppp_pkg::div_work_t in_work,
	output logic               out_valid,
	output ppp_pkg::div_work_t out_work
);

	logic [ppp_pkg::MAG_W:0]   shift_u, shift_v;
	logic [ppp_pkg::MAG_W+1:0] diff_u, diff_v;
	logic                      ge_u, ge_v;
	ppp_pkg::div_work_t        next_work;
	ppp_pkg::div_work_t        work_q;
	logic                      valid_q;

	// restoring step: bring in the next dividend bit, subtract when it fits
	always_comb begin
		shift_u = {in_work.rem_u, in_work.num_lo_u[ppp_pkg::QUOT_W-1]};
		shift_v = {in_work.rem_v, in_work.num_lo_v[ppp_pkg::QUOT_W-1]};
		diff_u  = {1'b0, shift_u} - {2'b00, in_work.den};
		diff_v  = {1'b0, shift_v} - {2'b00, in_work.den};
		ge_u    = !diff_u[ppp_pkg::MAG_W+1];
		ge_v    = !diff_v[ppp_pkg::MAG_W+1];

		next_work          = in_work;
		next_work.rem_u    = ge_u ? diff_u[ppp_pkg::MAG_W-1:0] : shift_u[ppp_pkg::MAG_W-1:0];
		next_work.rem_v    = ge_v ? diff_v[ppp_pkg::MAG_W-1:0] : shift_v[ppp_pkg::MAG_W-1:0];
		next_work.num_lo_u = {in_work.num_lo_u[ppp_pkg::QUOT_W-2:0], 1'b0};
		next_work.num_lo_v = {in_work.num_lo_v[ppp_pkg::QUOT_W-2:0], 1'b0};
		next_work.quo_u    = {in_work.quo_u[ppp_pkg::QUOT_W-2:0], ge_u};
		next_work.quo_v    = {in_work.quo_v[ppp_pkg::QUOT_W-2:0], ge_v};
	end

	// cell valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	// cell payload
	always_ff @(posedge clk) begin
		if (en) begin
			work_q <= next_work;
		end
	end

	assign out_valid = valid_q;
	assign out_work  = work_q;

endmodule

`default_nettype wire

@@ sv/ppp_out_skid.sv @@
// two-entry output buffer: result register plus skid register
`timescale 1ns / 1ps
`default_nettype none

module ppp_out_skid (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ppp_pkg::result_t push_data,
	output logic             ready,
	ppp_result_if.source     result
);

	ppp_pkg::result_t out_q, skid_q;
	logic             out_valid_q, skid_valid_q;
	logic             pop;

	assign pop   = out_valid_q & result.ready;
	assign ready = !skid_valid_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q  <= skid_valid_q | push;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q) begin
			out_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// data: skid drains first, new results park in skid while out is held
	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= skid_valid_q ? skid_q : push_data;
		end else if (!out_valid_q) begin
			out_q <= push_data;
		end
		if (!pop && out_valid_q && push) begin
			skid_q <= push_data;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.image_u = out_q.image_u;
	assign result.image_v = out_q.image_v;
	assign result.status  = out_q.status;

endmodule

`default_nettype wire

@@ sv/perspective_point_projection.sv @@
// top level: 3x4 pinhole projection of fixed-point points
`timescale 1ns / 1ps
`default_nettype none

// Projects one camera-space point (x, y, z) per transfer through the 3x4 matrix held in six
// 64-bit registers and returns u = row1.P / row3.P and v = row2.P / row3.P, truncated toward
// zero and saturated to signed 32 bits with FRAC_BITS fraction bits; status is 1 for a zero
// denominator (u and v zero) and 2 when either quotient saturated. A new point is taken every
// clock while point.ready is high; a result passes through all of the pipeline's stages:
// 38 register stages in all, five front-end stages (products, two adder levels, magnitude,
// divider setup), then a chain of 32 divider cells, one quotient bit of u and v per cell,
// then the output register. While the output register and its skid entry are both full the
// whole pipeline holds and point.ready is low. Register writes with an index above five are
// dropped; write the registers only while no point is in flight.
`include "perspective_point_projection_defines.svh"

module perspective_point_projection #(
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [ppp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ppp_pkg::REG_W-1:0]       cfg_data,
	ppp_point_if.sink                       point,
	ppp_result_if.source                    result
);

	localparam int NUM_CELLS = ppp_pkg::QUOT_W;

	logic [ppp_pkg::REG_W-1:0] cfg_q [ppp_pkg::NUM_REGS];
	ppp_pkg::matrix_t          matrix;
	logic                      pipe_en;
	logic                      chain_valid [NUM_CELLS+1];
	ppp_pkg::div_work_t        chain_work  [NUM_CELLS+1];
	ppp_pkg::result_t          fin;
	logic [ppp_pkg::QUOT_W:0]  lane_u, lane_v;

	// sign fix and saturation of one quotient, returns {saturated, value}
	function automatic logic [ppp_pkg::QUOT_W:0] lane_result(
		input logic [ppp_pkg::QUOT_W-1:0] quo,
		input logic                       neg,
		input logic                       big
	);
		logic                      sat;
		logic [ppp_pkg::QUOT_W-1:0] val;
		if (neg) begin
			sat = big | (quo[ppp_pkg::QUOT_W-1] & (|quo[ppp_pkg::QUOT_W-2:0]));
			val = sat ? ppp_pkg::QUOT_NEG_MAX : (~quo + 1'b1);
		end else begin
			sat = big | quo[ppp_pkg::QUOT_W-1];
			val = sat ? ppp_pkg::QUOT_POS_MAX : quo;
		end
		return {sat, val};
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ppp_pkg::NUM_REGS; i++) begin
				cfg_q[i] <= '0;
			end
		end else if (cfg_wr_en) begin
			for (int i = 0; i < ppp_pkg::NUM_REGS; i++) begin
				if (cfg_index == ppp_pkg::CFG_IDX_W'(i)) begin
					cfg_q[i] <= cfg_data;
				end
			end
		end
	end

	// unpack registers into matrix rows
	always_comb begin
		matrix[ppp_pkg::ROW_U][ppp_pkg::COEF_X]   = cfg_q[ppp_pkg::REG_ROW1_AB][31:0];
		matrix[ppp_pkg::ROW_U][ppp_pkg::COEF_Y]   = cfg_q[ppp_pkg::REG_ROW1_AB][63:32];
		matrix[ppp_pkg::ROW_U][ppp_pkg::COEF_Z]   = cfg_q[ppp_pkg::REG_ROW1_CD][31:0];
		matrix[ppp_pkg::ROW_U][ppp_pkg::COEF_ONE] = cfg_q[ppp_pkg::REG_ROW1_CD][63:32];
		matrix[ppp_pkg::ROW_V][ppp_pkg::COEF_X]   = cfg_q[ppp_pkg::REG_ROW2_AB][31:0];
		matrix[ppp_pkg::ROW_V][ppp_pkg::COEF_Y]   = cfg_q[ppp_pkg::REG_ROW2_AB][63:32];
		matrix[ppp_pkg::ROW_V][ppp_pkg::COEF_Z]   = cfg_q[ppp_pkg::REG_ROW2_CD][31:0];
		matrix[ppp_pkg::ROW_V][ppp_pkg::COEF_ONE] = cfg_q[ppp_pkg::REG_ROW2_CD][63:32];
		matrix[ppp_pkg::ROW_D][ppp_pkg::COEF_X]   = cfg_q[ppp_pkg::REG_ROW3_AB][31:0];
		matrix[ppp_pkg::ROW_D][ppp_pkg::COEF_Y]   = cfg_q[ppp_pkg::REG_ROW3_AB][63:32];
		matrix[ppp_pkg::ROW_D][ppp_pkg::COEF_Z]   = cfg_q[ppp_pkg::REG_ROW3_CD][31:0];
		matrix[ppp_pkg::ROW_D][ppp_pkg::COEF_ONE] = cfg_q[ppp_pkg::REG_ROW3_CD][63:32];
	end

	// dot products and divider setup
	ppp_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.point     (point),
		.matrix    (matrix),
		.div_valid (chain_valid[0]),
		.div_work  (chain_work[0])
	);

	// divider chain, most significant quotient bit first
	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		ppp_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (pipe_en),
			.in_valid  (chain_valid[k]),
			.in_work   (chain_work[k]),
			.out_valid (chain_valid[k+1]),
			.out_work  (chain_work[k+1])
		);
	end

	// final sign, saturation and status
	always_comb begin
		lane_u = lane_result(chain_work[NUM_CELLS].quo_u, chain_work[NUM_CELLS].neg_u,
		                     chain_work[NUM_CELLS].big_u);
		lane_v = lane_result(chain_work[NUM_CELLS].quo_v, chain_work[NUM_CELLS].neg_v,
		                     chain_work[NUM_CELLS].big_v);
		if (chain_work[NUM_CELLS].zero_den) begin
			fin.image_u = '0;
			fin.image_v = '0;
			fin.status  = ppp_pkg::STATUS_ZERO_DEN;
		end else begin
			fin.image_u = $signed(lane_u[ppp_pkg::QUOT_W-1:0]);
			fin.image_v = $signed(lane_v[ppp_pkg::QUOT_W-1:0]);
			fin.status  = (lane_u[ppp_pkg::QUOT_W] | lane_v[ppp_pkg::QUOT_W])
			            ? ppp_pkg::STATUS_SAT : ppp_pkg::STATUS_OK;
		end
	end

	// output register with skid entry
	ppp_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (chain_valid[NUM_CELLS] & pipe_en),
		.push_data (fin),
		.ready     (pipe_en),
		.result    (result)
	);

	// a held pipeline means the output side is full
	`PPP_ASSERT_HOLDS(a_stall_has_result, !pipe_en, result.valid)
	// the chain end does not move while the pipeline holds
	`PPP_ASSERT_NEXT(a_stall_freezes_chain, !pipe_en, $stable(chain_valid[NUM_CELLS]) && $stable(chain_work[NUM_CELLS]))
	// a zero denominator reports zero coordinates
	`PPP_ASSERT_HOLDS(a_zero_den_clears, result.valid && result.status == ppp_pkg::STATUS_ZERO_DEN, result.image_u == '0 && result.image_v == '0)
	// a saturated result has a coordinate at a limit
	`PPP_ASSERT_HOLDS(a_sat_at_limit, result.valid && result.status == ppp_pkg::STATUS_SAT, result.image_u == $signed(ppp_pkg::QUOT_POS_MAX) || result.image_u == $signed(ppp_pkg::QUOT_NEG_MAX) || result.image_v == $signed(ppp_pkg::QUOT_POS_MAX) || result.image_v == $signed(ppp_pkg::QUOT_NEG_MAX))

endmodule

`default_nettype wire
